[hdl/pfp_pkg.sv]
// Shared types, register indexes and channel scaling functions for the pixel format packer.
// No dependencies; used by pfp_pack and pixel_format_packer_top.
package pfp_pkg;

	localparam int CHAN_W    = 8;
	localparam int WORD_W    = 32;
	localparam int BYTES_W   = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_FORMAT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_HAS_ALPHA = 1'd1;

	// Valid byte counts
	localparam logic [BYTES_W-1:0] BYTES_2 = 3'd2;
	localparam logic [BYTES_W-1:0] BYTES_3 = 3'd3;
	localparam logic [BYTES_W-1:0] BYTES_4 = 3'd4;

	// Opaque alpha fills
	localparam logic [3:0]        ALPHA4_OPAQUE = 4'hF;
	localparam logic [CHAN_W-1:0] ALPHA8_OPAQUE = 8'hFF;

	typedef enum logic [2:0] {
		FMT_RGB565   = 3'd0,
		FMT_ARGB4444 = 3'd1,
		FMT_RGB888   = 3'd2,
		FMT_ARGB8888 = 3'd3,
		FMT_ARGB1555 = 3'd4
	} fmt_t;

	typedef struct packed {
		logic [2:0] fmt;
		logic       has_alpha;
	} cfg_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] alpha;
	} pixel_t;

	typedef struct packed {
		logic [WORD_W-1:0]  word;
		logic [BYTES_W-1:0] bytes;
	} packed_t;

	// floor(x*31/255): divide by 255 as (v + (v>>8) + 1) >> 8, exact for v < 65535
	function automatic logic [4:0] scale5(input logic [CHAN_W-1:0] x);
		logic [12:0] p;
		logic [13:0] t;
		begin
			p = 13'(x) * 13'd31;
			t = {1'b0, p} + 14'(p[12:8]) + 14'd1;
			return t[12:8];
		end
	endfunction

	// floor(x*63/255), same divide-by-255 trick
	function automatic logic [5:0] scale6(input logic [CHAN_W-1:0] x);
		logic [13:0] p;
		logic [14:0] t;
		begin
			p = 14'(x) * 14'd63;
			t = {1'b0, p} + 15'(p[13:8]) + 15'd1;
			return t[13:8];
		end
	endfunction

	// floor(x/17) as (x*241) >> 12, exact for all 8-bit x
	function automatic logic [3:0] scale4(input logic [CHAN_W-1:0] x);
		logic [15:0] p;
		begin
			p = 16'(x) * 16'd241;
			return p[15:12];
		end
	endfunction

endpackage

[hdl/pixel_format_packer_top.sv]
// Top level of the pixel format packer: config registers, input and result registers.
// Depends on pfp_pkg and pfp_pack.
//
// Converts one B, G, R, A byte pixel per beat into RGB565, ARGB4444, RGB888,
// ARGB8888 or ARGB1555 as chosen by output_format (register 0); unknown format
// codes give a zero word with two bytes. Register 1, input_has_alpha, forces the
// alpha field to opaque when cleared. A beat is taken on every edge where start
// is high; busy never rises, so a pixel may enter every cycle. Each pixel passes
// through two registers, the input register and then the result register, with
// the channel scaling (constant multiplies) in between.
// done marks the result for exactly one cycle and the receiver cannot stall it,
// so sample pixel_word and pixel_bytes whenever done is high. Write the
// configuration only while no pixel is in flight.
module pixel_format_packer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [pfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pfp_pkg::CFG_DAT_W-1:0] cfg_wdata,
	// pixel command
	input  logic                          start,
	output logic                          busy,
	input  logic [pfp_pkg::CHAN_W-1:0]    blue,
	input  logic [pfp_pkg::CHAN_W-1:0]    green,
	input  logic [pfp_pkg::CHAN_W-1:0]    red,
	input  logic [pfp_pkg::CHAN_W-1:0]    alpha,
	// result
	output logic                          done,
	output logic [pfp_pkg::WORD_W-1:0]    pixel_word,
	output logic [pfp_pkg::BYTES_W-1:0]   pixel_bytes
);

	pfp_pkg::cfg_t    cfg_q;
	pfp_pkg::pixel_t  pix_s1;
	logic             vld_s1;
	pfp_pkg::packed_t res_comb;
	pfp_pkg::packed_t res_s2;
	logic             vld_s2;
	logic             accept;

	// every pixel is independent, so never stall the sender
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Configuration registers: reset to RGB565 with alpha in use.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fmt       <= pfp_pkg::FMT_RGB565;
			cfg_q.has_alpha <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfp_pkg::REG_OUTPUT_FORMAT:   cfg_q.fmt       <= cfg_wdata;
				pfp_pkg::REG_INPUT_HAS_ALPHA: cfg_q.has_alpha <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Beat valids: advance one stage per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	// Payload: capture the pixel, then hold the packed result until the next one replaces it.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1.blue  <= blue;
			pix_s1.green <= green;
			pix_s1.red   <= red;
			pix_s1.alpha <= alpha;
		end
		if (vld_s1) begin
			res_s2 <= res_comb;
		end
	end

	pfp_pack u_pack (
		.cfg (cfg_q),
		.pix (pix_s1),
		.res (res_comb)
	);

	assign done        = vld_s2;
	assign pixel_word  = res_s2.word;
	assign pixel_bytes = res_s2.bytes;

	// Every taken beat produces a result.
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("accepted pixel produced no result");

	// No result without a matching beat taken earlier.
	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2))
		else $error("result without a matching pixel");

	// Byte count is always 2, 3 or 4.
	a_bytes_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pixel_bytes == pfp_pkg::BYTES_2 || pixel_bytes == pfp_pkg::BYTES_3 ||
			pixel_bytes == pfp_pkg::BYTES_4))
		else $error("illegal pixel_bytes");

	// Two-byte formats leave the upper half clear; three-byte leaves the top byte clear.
	a_upper_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && pixel_bytes == pfp_pkg::BYTES_2) |-> (pixel_word[31:16] == 16'd0))
		else $error("bits above a two-byte pixel are set");

	a_upper_clear3: assert property (@(posedge clk) disable iff (!arst_n)
		(done && pixel_bytes == pfp_pkg::BYTES_3) |-> (pixel_word[31:24] == 8'd0))
		else $error("bits above a three-byte pixel are set");

endmodule

[hdl/pfp_pack.sv]
// Combinational packer: scales channels and assembles one output pixel word.
// Depends on pfp_pkg.
module pfp_pack (
	input  pfp_pkg::cfg_t    cfg,
	input  pfp_pkg::pixel_t  pix,
	output pfp_pkg::packed_t res
);

	logic [4:0] r5, g5, b5;
	logic [5:0] g6;
	logic [3:0] r4, g4, b4, a4;
	logic       a1;
	logic [pfp_pkg::CHAN_W-1:0] a8;

	assign r5 = pfp_pkg::scale5(pix.red);
	assign g5 = pfp_pkg::scale5(pix.green);
	assign b5 = pfp_pkg::scale5(pix.blue);
	assign g6 = pfp_pkg::scale6(pix.green);
	assign r4 = pfp_pkg::scale4(pix.red);
	assign g4 = pfp_pkg::scale4(pix.green);
	assign b4 = pfp_pkg::scale4(pix.blue);

	// force opaque when the source carries no alpha
	assign a4 = cfg.has_alpha ? pfp_pkg::scale4(pix.alpha) : pfp_pkg::ALPHA4_OPAQUE;
	assign a8 = cfg.has_alpha ? pix.alpha : pfp_pkg::ALPHA8_OPAQUE;
	assign a1 = cfg.has_alpha ? (pix.alpha != '0) : 1'b1;

	always_comb begin
		unique case (cfg.fmt)
			pfp_pkg::FMT_RGB565: begin
				res.word  = {16'd0, r5, g6, b5};
				res.bytes = pfp_pkg::BYTES_2;
			end
			pfp_pkg::FMT_ARGB4444: begin
				res.word  = {16'd0, a4, r4, g4, b4};
				res.bytes = pfp_pkg::BYTES_2;
			end
			pfp_pkg::FMT_RGB888: begin
				res.word  = {8'd0, pix.red, pix.green, pix.blue};
				res.bytes = pfp_pkg::BYTES_3;
			end
			pfp_pkg::FMT_ARGB8888: begin
				res.word  = {a8, pix.red, pix.green, pix.blue};
				res.bytes = pfp_pkg::BYTES_4;
			end
			pfp_pkg::FMT_ARGB1555: begin
				res.word  = {16'd0, a1, r5, g5, b5};
				res.bytes = pfp_pkg::BYTES_2;
			end
			default: begin
				res.word  = '0;
				res.bytes = pfp_pkg::BYTES_2;
			end
		endcase
	end

endmodule
